### hdl/mtgen_pkg.sv
// Package for the MT19937 generator: table geometry, twist and tempering
// constants, and the tempering function. No dependencies.
`default_nettype none
package mtgen_pkg;

	localparam int unsigned STATE_WORDS_DEF = 624;
	localparam int unsigned MT_SHIFT        = 397;

	localparam logic REQ_RESEED = 1'b0;
	localparam logic REQ_DRAW   = 1'b1;

	localparam logic [31:0] MT_MATRIX    = 32'h9908_B0DF;
	localparam logic [31:0] MT_TEMPER_B  = 32'h9D2C_5680;
	localparam logic [31:0] MT_TEMPER_C  = 32'hEFC6_0000;
	localparam logic [31:0] MT_INIT_MULT = 32'h6C07_8965;
	localparam logic [31:0] MT_UPPER     = 32'h8000_0000;
	localparam logic [31:0] MT_LOWER     = 32'h7FFF_FFFF;

	typedef logic [31:0] word_t;

	function automatic word_t mt_temper(input word_t x_in);
		word_t x;
		x = x_in;
		x = x ^ (x >> 11);
		x = x ^ ((x << 7) & MT_TEMPER_B);
		x = x ^ ((x << 15) & MT_TEMPER_C);
		x = x ^ (x >> 18);
		return x;
	endfunction

endpackage
`default_nettype wire

### hdl/mtgen_table.sv
// Twist table storage: one write port, two registered read ports.
// Depends on mtgen_pkg for the word type.
`default_nettype none
module mtgen_table #(
	parameter int unsigned DEPTH = mtgen_pkg::STATE_WORDS_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [AW-1:0]       wr_addr,
	input  wire mtgen_pkg::word_t    wr_data,
	input  wire logic                rd_en,
	input  wire logic [AW-1:0]       rd_addr_a,
	input  wire logic [AW-1:0]       rd_addr_b,
	output mtgen_pkg::word_t         rd_data_a,
	output mtgen_pkg::word_t         rd_data_b
);
	import mtgen_pkg::*;

	word_t mem [DEPTH];
	word_t rd_a_q;
	word_t rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule
`default_nettype wire

### hdl/mt19937_generator.sv
// MT19937 generator top level. Depends on mtgen_pkg and mtgen_table.
// Draw: the transfer issues the table reads, then ST_DRAW twists and writes back; the
//   write-back holds while the previous result is still untaken.
// Reseed: the transfer writes word 0, then ST_SEED does one init multiply a cycle.
// Reset clears control state only; the table is undefined until the first reseed.
`default_nettype none
module mt19937_generator #(
	parameter int unsigned STATE_WORDS = mtgen_pkg::STATE_WORDS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             req_type,
	input  wire mtgen_pkg::word_t seed,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output mtgen_pkg::word_t      value
);
	import mtgen_pkg::*;

	localparam int unsigned AW  = $clog2(STATE_WORDS);
	localparam int unsigned AW1 = AW + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SEED = 2'd1;
	localparam logic [1:0] ST_DRAW = 2'd2;

	logic [1:0]    state_q;
	logic [AW-1:0] index_q;
	logic [AW-1:0] cnt_q;
	logic          seeded_q;
	logic          out_valid_q;
	word_t         value_q;
	word_t         cur_q;
	word_t         prev_q;

	logic          acc;
	logic          acc_seed;
	logic          acc_draw;
	logic          wb_go;
	logic [AW-1:0] nx_idx;
	logic [AW-1:0] fa_idx;
	logic [AW:0]   fa_sum;
	word_t         rd_nx;
	word_t         rd_fa;
	word_t         y;
	word_t         w;
	word_t         init_next;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	word_t         wr_data;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;
	assign acc_seed = acc && (req_type == REQ_RESEED);
	assign acc_draw = acc && (req_type != REQ_RESEED);
	assign wb_go    = (state_q == ST_DRAW) && (!out_valid_q || out_ready);

	always_comb begin
		nx_idx = (index_q == AW'(STATE_WORDS - 1)) ? '0 : index_q + AW'(1);
		fa_sum = {1'b0, index_q} + AW1'(MT_SHIFT);
		if (fa_sum >= AW1'(STATE_WORDS)) begin
			fa_sum = fa_sum - AW1'(STATE_WORDS);
		end
		fa_idx = fa_sum[AW-1:0];
	end

	always_comb begin
		y = (cur_q & MT_UPPER) | (rd_nx & MT_LOWER);
		w = rd_fa ^ (y >> 1) ^ (y[0] ? MT_MATRIX : '0);
		if (!seeded_q) begin
			w = '0;
		end
		init_next = (MT_INIT_MULT * (prev_q ^ (prev_q >> 30))) + {{(32-AW){1'b0}}, cnt_q};
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = index_q;
		wr_data = w;
		if (acc_seed) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = seed;
		end else if (state_q == ST_SEED) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q;
			wr_data = init_next;
		end else if (wb_go) begin
			wr_en = 1'b1;
		end
	end

	mtgen_table #(
		.DEPTH(STATE_WORDS),
		.AW   (AW)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (acc_draw),
		.rd_addr_a(nx_idx),
		.rd_addr_b(fa_idx),
		.rd_data_a(rd_nx),
		.rd_data_b(rd_fa)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			index_q     <= '0;
			cnt_q       <= '0;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc_seed) begin
						state_q  <= ST_SEED;
						cnt_q    <= AW'(1);
						index_q  <= '0;
						seeded_q <= 1'b1;
					end else if (acc_draw) begin
						state_q <= ST_DRAW;
					end
				end
				ST_SEED: begin
					cnt_q <= cnt_q + AW'(1);
					if (cnt_q == AW'(STATE_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DRAW: begin
					if (wb_go) begin
						index_q     <= nx_idx;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_seed) begin
			prev_q <= seed;
			cur_q  <= seed;
		end else if (state_q == ST_SEED) begin
			prev_q <= init_next;
		end
		if (wb_go) begin
			cur_q   <= rd_nx;
			value_q <= mt_temper(w);
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		index_q < AW'(STATE_WORDS))
		else $error("draw index out of range");

	a_draw_result: assert property (@(posedge clk) disable iff (!arst_n)
		wb_go |=> out_valid && (state_q == ST_IDLE))
		else $error("write-back did not raise result");

	a_seed_start: assert property (@(posedge clk) disable iff (!arst_n)
		acc_seed |=> (state_q == ST_SEED) && (cnt_q == AW'(1)) && (index_q == '0))
		else $error("reseed did not start");

	a_seed_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEED) && (cnt_q == AW'(STATE_WORDS - 1)) |=>
		(state_q == ST_IDLE) && seeded_q)
		else $error("reseed did not finish");

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for mt19937_generator: a queue-fed driver, a monitor and a
// shadow MT19937 table that predicts every drawn word. Depends on mtgen_pkg.
`default_nettype none
module tb_top;
	import mtgen_pkg::*;

	localparam int unsigned TABLE_WORDS = STATE_WORDS_DEF;
	localparam int unsigned IDLE_PCT     = 21;
	localparam int unsigned QUIET_FROM   = 5500;
	localparam int unsigned QUIET_TO     = 7500;
	localparam int unsigned STALL_AFTER  = 60;
	localparam int unsigned STALL_CYCLES = 400;
	localparam int unsigned TAIL_CYCLES  = 700;

	typedef struct {
		logic  kind;
		word_t seed_val;
		bit    drain_first;
	} mt_req_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	logic  req_type = REQ_RESEED;
	word_t seed = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	word_t value;

	mt_req_t     pending_reqs[$];
	word_t       expected_words[$];
	word_t       shadow_table[TABLE_WORDS];
	int unsigned shadow_idx = 0;
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_cnt = 0;
	int unsigned stall_left = 0;
	bit          stall_done = 1'b0;
	logic        in_fire = 1'b0;
	logic        idle_ok;

	mt19937_generator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.seed      (seed),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	assign idle_ok = (cycle_cnt < QUIET_FROM) || (cycle_cnt >= QUIET_TO);

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic word_t temper_word(input word_t w);
		word_t t;
		t = w;
		t ^= t >> 11;
		t ^= (t << 7) & MT_TEMPER_B;
		t ^= (t << 15) & MT_TEMPER_C;
		t ^= t >> 18;
		return t;
	endfunction

	function automatic void load_seed(input word_t s);
		word_t prev;
		prev = s;
		shadow_table[0] = s;
		for (int unsigned i = 1; i < TABLE_WORDS; i++) begin
			prev = MT_INIT_MULT * (prev ^ (prev >> 30)) + word_t'(i);
			shadow_table[i] = prev;
		end
		shadow_idx = 0;
	endfunction

	function automatic word_t draw_word();
		int unsigned nx;
		int unsigned far;
		word_t       mixed;
		word_t       twisted;
		nx = (shadow_idx + 1) % TABLE_WORDS;
		far = (shadow_idx + MT_SHIFT) % TABLE_WORDS;
		mixed = (shadow_table[shadow_idx] & MT_UPPER) | (shadow_table[nx] & MT_LOWER);
		twisted = shadow_table[far] ^ (mixed >> 1);
		if (mixed[0])
			twisted ^= MT_MATRIX;
		shadow_table[shadow_idx] = twisted;
		shadow_idx = nx;
		return temper_word(twisted);
	endfunction

	task automatic push_req(input logic kind, input word_t s, input bit drain);
		mt_req_t r;
		r.kind = kind;
		r.seed_val = s;
		r.drain_first = drain;
		pending_reqs.push_back(r);
	endtask

	always @(posedge clk) begin : monitor
		word_t want;
		cycle_cnt <= cycle_cnt + 1;
		in_fire <= arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (expected_words.size() == 0) begin
				flag_mismatch($sformatf("value %08h with nothing expected", value));
			end else begin
				want = expected_words.pop_front();
				if (value !== want)
					flag_mismatch($sformatf("value %08h, expected %08h", value, want));
			end
		end
		if (arst_n && in_valid && in_ready) begin
			if (req_type == REQ_RESEED)
				load_seed(seed);
			else
				expected_words.push_back(draw_word());
		end
	end

	always @(negedge clk) begin : driver
		mt_req_t r;
		if (arst_n && (!in_valid || in_fire)) begin
			if (pending_reqs.size() != 0 && pending_reqs[0].drain_first
					&& expected_words.size() != 0) begin
				in_valid <= 1'b0;
			end else if (pending_reqs.size() != 0
					&& !(idle_ok && $urandom_range(0, 99) < IDLE_PCT)) begin
				r = pending_reqs.pop_front();
				req_type <= r.kind;
				seed <= r.seed_val;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!stall_done && results_seen >= STALL_AFTER) begin
			stall_done <= 1'b1;
			stall_left <= STALL_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(idle_ok && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	initial begin : stimulus
		word_t s;
		push_req(REQ_RESEED, 32'h0000_0000, 1'b0);
		push_req(REQ_DRAW, 32'h0000_0000, 1'b0);
		push_req(REQ_DRAW, 32'hFFFF_FFFF, 1'b0);
		push_req(REQ_DRAW, $urandom, 1'b0);
		push_req(REQ_RESEED, 32'hFFFF_FFFF, 1'b0);
		push_req(REQ_DRAW, $urandom, 1'b0);
		push_req(REQ_DRAW, $urandom, 1'b0);
		push_req(REQ_RESEED, 32'd5489, 1'b0);
		push_req(REQ_DRAW, 32'h0000_0000, 1'b0);
		push_req(REQ_DRAW, 32'hFFFF_FFFF, 1'b0);
		push_req(REQ_DRAW, $urandom, 1'b0);
		push_req(REQ_RESEED, 32'h8000_0000, 1'b0);
		push_req(REQ_RESEED, 32'h7FFF_FFFF, 1'b0);
		push_req(REQ_DRAW, $urandom, 1'b0);
		push_req(REQ_DRAW, $urandom, 1'b0);
		push_req(REQ_RESEED, 32'h0000_0001, 1'b1);
		push_req(REQ_DRAW, $urandom, 1'b0);
		push_req(REQ_DRAW, $urandom, 1'b0);

		// long unbroken draw run first so the index wraps past the table end
		for (int n = 0; n < 1000; n++) begin
			if (n == 0 || (n > 700 && $urandom_range(0, 39) == 0)) begin
				case ($urandom_range(0, 9))
					0: s = 32'h0000_0000;
					1: s = 32'hFFFF_FFFF;
					default: s = $urandom;
				endcase
				push_req(REQ_RESEED, s, 1'b0);
			end else begin
				push_req(REQ_DRAW, $urandom, n == 850);
			end
		end

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_words.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (expected_words.size() != 0)
			flag_mismatch($sformatf("%0d values never arrived", expected_words.size()));
		if (mismatches == 0)
			$display("PASS mt19937_generator");
		else
			$display("FAIL mt19937_generator");
		$finish;
	end

	initial begin : watchdog
		#400000;
		$display("FAIL mt19937_generator");
		$finish;
	end

endmodule
`default_nettype wire
